// ===== sv/indexed_deque_with_rotate_macros.svh =====
// assertion macros shared by the indexed deque rtl
`ifndef INDEXED_DEQUE_WITH_ROTATE_MACROS_SVH
`define INDEXED_DEQUE_WITH_ROTATE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define IDWR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("indexed deque check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define IDWR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("indexed deque check failed");

`endif

// ===== sv/idwr_pkg.sv =====
// shared codes and types for the indexed deque
`timescale 1ns / 1ps

package idwr_pkg;

    // request operation codes, codes 5 to 7 are unused
    localparam logic [2:0] MODE_APPEND = 3'd0;
    localparam logic [2:0] MODE_INSERT = 3'd1;
    localparam logic [2:0] MODE_READ   = 3'd2;
    localparam logic [2:0] MODE_REMOVE = 3'd3;
    localparam logic [2:0] MODE_ROTATE = 3'd4;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FAIL  = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    // field widths of the stream payloads
    localparam int MODE_W   = 3;
    localparam int POS_W    = 6;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 48;

    // move broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_ROTATE
    } cell_op_t;

endpackage

// ===== sv/idwr_cell.sv =====
// one storage cell of the deque chain with its shift mux
`timescale 1ns / 1ps

module idwr_cell #(
    parameter int EW  = 32,
    parameter int IW  = 7,
    parameter int IDX = 0
) (
    input  logic                clk,
    input  idwr_pkg::cell_op_t  op,
    input  logic [IW-1:0]       count,
    input  logic [IW-1:0]       pos,
    input  logic [EW-1:0]       load_word,
    input  logic [EW-1:0]       left_word,
    input  logic [EW-1:0]       right_word,
    output logic [EW-1:0]       word,
    output logic [EW-1:0]       rd_word
);

    localparam logic [IW-1:0] IDX_V  = IW'(IDX);
    localparam logic [IW-1:0] IDX_P1 = IW'(IDX + 1);

    logic [EW-1:0] word_reg;
    logic [EW-1:0] word_next;

    // pick the new content from the broadcast move
    always_comb
    begin
        word_next = word_reg;
        unique case (op)
            idwr_pkg::CELL_APPEND:
            begin
                if (IDX_V == count)
                    word_next = load_word;
            end
            idwr_pkg::CELL_INSERT:
            begin
                if (IDX_V == '0)
                    word_next = load_word;
                else if (IDX_V <= count)
                    word_next = left_word;
            end
            idwr_pkg::CELL_REMOVE:
            begin
                if (IDX_V >= pos && IDX_P1 < count)
                    word_next = right_word;
            end
            idwr_pkg::CELL_ROTATE:
            begin
                if (IDX_P1 < count)
                    word_next = right_word;
                else if (IDX_P1 == count)
                    word_next = load_word;
            end
            idwr_pkg::CELL_HOLD:
            begin
                word_next = word_reg;
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    // word gated onto the read tree when this cell is addressed
    assign rd_word = (pos == IDX_V) ? word_reg : '0;
    assign word    = word_reg;

endmodule

// ===== sv/indexed_deque_with_rotate.sv =====
// top level of the indexed deque: cell chain, read tree and result register
//
// Usage:
//   Requests come in on s_axis (mode, position, event_word); each one gives
//   exactly one result on m_axis (status, read_word, entry_count).
//   Append and insert add a word at the back or front, read returns the
//   entry at a position, remove closes the gap behind it, rotate moves the
//   front entry to the back. All cells move together: each cell of
//   the chain loads from itself, its left or right neighbor or the load
//   word (the request word, or on rotate the old front entry). A request
//   passes the request stage, the read tree stage (between the two levels
//   of the read tree) and the result register. One request is in flight
//   at a time. The result register holds the finished result while the
//   next request is taken and run; that request then waits in the
//   pipeline until the receiver raises m_axis_tready.
//   Reset clears the count and the control state; entry contents are not
//   cleared and are only read below the count.
`timescale 1ns / 1ps
`include "indexed_deque_with_rotate_macros.svh"

module indexed_deque_with_rotate #(
    parameter int DEPTH       = 64,
    parameter int EVENT_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // mode[2:0], position[8:3], event_word[40:9], zero fill[47:41]
    input  logic [idwr_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // status[1:0], read_word[33:2], entry_count[40:34], zero fill[47:41]
    output logic [idwr_pkg::OUT_W-1:0]  m_axis_tdata
);

    localparam int EW  = EVENT_WIDTH;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int IW  = (CW > idwr_pkg::POS_W) ? CW : idwr_pkg::POS_W;
    localparam int GS  = 8;
    localparam int NG  = (DEPTH + GS - 1) / GS;
    localparam int PADW = idwr_pkg::OUT_W - idwr_pkg::STATUS_W - idwr_pkg::WORD_W
                          - idwr_pkg::COUNT_W;

    // request stage
    logic                          a_valid_reg;
    logic [idwr_pkg::MODE_W-1:0]   a_mode_reg;
    logic [idwr_pkg::POS_W-1:0]    a_pos_reg;
    logic [EW-1:0]                 a_word_reg;

    // read tree stage
    logic                          b_valid_reg;
    logic [idwr_pkg::STATUS_W-1:0] b_status_reg;
    logic [idwr_pkg::COUNT_W-1:0]  b_count_reg;
    logic                          b_read_reg;
    logic [EW-1:0]                 b_group_reg [NG];

    // result register
    logic                          m_valid_reg;
    logic [idwr_pkg::OUT_W-1:0]    m_data_reg;

    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;

    logic                          in_fire;
    logic                          b_move;
    logic [EW+31:0]                in_word_wide;
    logic [EW-1:0]                 in_word;
    logic [IW-1:0]                 count_x;
    logic [IW-1:0]                 pos_x;
    logic                          full;
    logic                          pos_ok;
    logic [idwr_pkg::STATUS_W-1:0] status;
    logic                          read_ok;
    idwr_pkg::cell_op_t            cell_op;
    logic [EW-1:0]                 load_word;
    logic [CW+6:0]                 count_wide;
    logic [EW-1:0]                 words    [DEPTH];
    logic [EW-1:0]                 rd_words [DEPTH];
    logic [EW-1:0]                 group_or [NG];
    logic [EW-1:0]                 tree_word;
    logic [EW+31:0]                tree_wide;
    logic [idwr_pkg::WORD_W-1:0]   read_word;

    assign s_axis_tready = !a_valid_reg && !b_valid_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign b_move        = b_valid_reg && (!m_valid_reg || m_axis_tready);

    // event word kept to the stored width
    assign in_word_wide = (EW + 32)'(s_axis_tdata[40:9]);
    assign in_word      = in_word_wide[EW-1:0];

    // decode the request against the current count
    assign count_x = IW'(count_reg);
    assign pos_x   = IW'(a_pos_reg);
    assign full    = (count_reg == CW'(DEPTH));
    assign pos_ok  = (pos_x < count_x);

    always_comb
    begin
        status     = idwr_pkg::ST_DONE;
        cell_op    = idwr_pkg::CELL_HOLD;
        count_next = count_reg;
        read_ok    = 1'b0;
        unique case (a_mode_reg)
            idwr_pkg::MODE_APPEND:
            begin
                if (full)
                    status = idwr_pkg::ST_FAIL;
                else
                begin
                    cell_op    = idwr_pkg::CELL_APPEND;
                    count_next = count_reg + 1'b1;
                end
            end
            idwr_pkg::MODE_INSERT:
            begin
                if (full)
                    status = idwr_pkg::ST_FAIL;
                else
                begin
                    cell_op    = idwr_pkg::CELL_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            idwr_pkg::MODE_READ:
            begin
                if (!pos_ok)
                    status = idwr_pkg::ST_FAIL;
                else
                    read_ok = 1'b1;
            end
            idwr_pkg::MODE_REMOVE:
            begin
                if (!pos_ok)
                    status = idwr_pkg::ST_FAIL;
                else
                begin
                    cell_op    = idwr_pkg::CELL_REMOVE;
                    count_next = count_reg - 1'b1;
                end
            end
            idwr_pkg::MODE_ROTATE:
            begin
                if (count_reg < CW'(2))
                    status = idwr_pkg::ST_SHORT;
                else
                    cell_op = idwr_pkg::CELL_ROTATE;
            end
            default:
            begin
                status = idwr_pkg::ST_FAIL;
            end
        endcase
        if (!a_valid_reg)
        begin
            cell_op    = idwr_pkg::CELL_HOLD;
            count_next = count_reg;
        end
    end

    // rotate reloads the old front entry at the back
    assign load_word  = (a_mode_reg == idwr_pkg::MODE_ROTATE) ? words[0] : a_word_reg;
    assign count_wide = (CW + 7)'(count_next);

    // chain of cells, each fed by its two neighbors
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        idwr_cell #(
            .EW  (EW),
            .IW  (IW),
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .op         (cell_op),
            .count      (count_x),
            .pos        (pos_x),
            .load_word  (load_word),
            .left_word  ((i == 0) ? load_word : words[(i == 0) ? 0 : i - 1]),
            .right_word ((i == DEPTH - 1) ? words[i] : words[(i == DEPTH - 1) ? i : i + 1]),
            .word       (words[i]),
            .rd_word    (rd_words[i])
        );
    end

    // first level of the read tree: or over groups of eight cells
    for (genvar g = 0; g < NG; g++)
    begin : g_group
        always_comb
        begin
            group_or[g] = '0;
            for (int k = 0; k < GS; k++)
            begin
                if (g * GS + k < DEPTH)
                    group_or[g] = group_or[g] | rd_words[g * GS + k];
            end
        end
    end

    // second level of the read tree over the group registers
    always_comb
    begin
        tree_word = '0;
        for (int g = 0; g < NG; g++)
            tree_word = tree_word | b_group_reg[g];
    end

    assign tree_wide = (EW + 32)'(tree_word);
    assign read_word = b_read_reg ? tree_wide[31:0] : '0;

    // control state and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_fire)
                a_valid_reg <= 1'b1;
            else if (a_valid_reg)
                a_valid_reg <= 1'b0;
            if (a_valid_reg)
                b_valid_reg <= 1'b1;
            else if (b_move)
                b_valid_reg <= 1'b0;
            if (b_move)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // payload registers of the three stages
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_mode_reg <= s_axis_tdata[2:0];
            a_pos_reg  <= s_axis_tdata[8:3];
            a_word_reg <= in_word;
        end
        if (a_valid_reg)
        begin
            b_status_reg <= status;
            b_count_reg  <= count_wide[6:0];
            b_read_reg   <= read_ok;
            for (int g = 0; g < NG; g++)
                b_group_reg[g] <= group_or[g];
        end
        if (b_move)
            m_data_reg <= {{PADW{1'b0}}, b_count_reg, read_word, b_status_reg};
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // checks on the pipeline and the count
    `IDWR_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    `IDWR_ASSERT_NOW(a_one_in_flight, 1'b1, $onehot0({a_valid_reg, b_valid_reg}))
    `IDWR_ASSERT_NEXT(a_accept_to_stage, in_fire, a_valid_reg && !b_valid_reg)
    `IDWR_ASSERT_NEXT(a_append_grows,
        a_valid_reg && a_mode_reg == idwr_pkg::MODE_APPEND && !full,
        count_reg == $past(count_reg) + 1'b1)
    `IDWR_ASSERT_NEXT(a_fail_keeps_count,
        a_valid_reg && status != idwr_pkg::ST_DONE,
        count_reg == $past(count_reg))

endmodule
